// ===== design/hsfe_pkg.sv =====
// Shared types and constants for the scrambled HDLC frame encoder.
// Used by the bit engine, the output queue and the top level.
package hsfe_pkg;

    localparam logic [7:0]  HDLC_FLAG = 8'h7E;
    localparam int          SCR_W     = 17;
    localparam logic [15:0] FCS_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h8408;

    // item kind on the input tuser
    localparam logic [1:0] FUNC_FLAG = 2'd0;
    localparam logic [1:0] FUNC_BODY = 2'd1;
    localparam logic [1:0] FUNC_END  = 2'd2;

    // steps of the end-of-frame sequence
    localparam logic [1:0] STEP_FCS_LO  = 2'd0;
    localparam logic [1:0] STEP_FCS_HI  = 2'd1;
    localparam logic [1:0] STEP_FLAG_A  = 2'd2;
    localparam logic [1:0] STEP_FLAG_B  = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // one byte operation handed to the bit engine
    typedef struct packed {
        logic [7:0]       data;
        logic             stuffed;
        logic             close;
        logic             scramble;
        logic             invert;
        logic [SCR_W-1:0] hist;
        logic [2:0]       ones;
        logic [7:0]       pbyte;
        logic [2:0]       pcnt;
    } t_eng_in;

    typedef struct packed {
        logic [SCR_W-1:0] hist;
        logic [2:0]       ones;
        logic [7:0]       pbyte;
        logic [2:0]       pcnt;
        logic [1:0]       nbytes;
        logic [7:0]       byte0;
        logic [7:0]       byte1;
    } t_eng_out;

    typedef struct packed {
        logic [7:0] data;
        logic       item_last;
        logic       frame_last;
    } t_out_ent;

endpackage

// ===== design/hdlc_scrambled_frame_encoder_core.sv =====
// Top level of the scrambled HDLC frame encoder: input register, frame sequencer,
// FCS and bit-engine state. Uses hsfe_pkg, hsfe_bit_engine and hsfe_out_queue.
//
// The block turns preamble flags, body bytes and end marks into a transmit byte
// stream with a reflected CRC-16 FCS. Each item is held in an input register and
// split into byte operations: a flag or body byte is one operation, an end mark is
// three in scrambled mode (FCS low, FCS high, closing flag with padded tail) and
// four in raw mode (FCS low, FCS high, two flags). The bit engine runs one
// operation per clock and yields up to two bytes into a four-entry output queue;
// an operation waits while the queue has fewer than two free slots. The output
// side moves one byte per cycle while m_axis_tready is high; a body byte yields
// one or two bytes and a frame close up to five, all leaving the input register
// through the output queue. Register writes take effect at the next frame start.
module hdlc_scrambled_frame_encoder_core
    import hsfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [SCR_W-1:0] i_cfg_data,
    // input items
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]       s_axis_tuser,   // [1:0] func
    // result items
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [0:0]       m_axis_tuser,   // [0] item_last
    output logic             m_axis_tlast    // frame_last
);

    localparam logic [1:0] CFG_SCR_EN = 2'd0;
    localparam logic [1:0] CFG_SEED   = 2'd1;
    localparam logic [1:0] CFG_INV    = 2'd2;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic             r_cfg_scr;
    logic [SCR_W-1:0] r_cfg_seed;
    logic             r_cfg_inv;

    logic             r_in_valid;
    logic [1:0]       r_func;
    logic [7:0]       r_data;
    logic [1:0]       r_step;

    logic [SCR_W-1:0] r_hist;
    logic [15:0]      r_fcs;
    logic [2:0]       r_ones;
    logic [7:0]       r_pbyte;
    logic [2:0]       r_pcnt;
    logic             r_in_frame;
    logic             r_lat_scr;
    logic             r_lat_inv;

    logic             w_start;
    logic             w_eff_scr;
    logic             w_eff_inv;
    logic [15:0]      w_eff_fcs;
    logic [15:0]      w_fcs_tx;
    logic             w_active;
    logic             w_final;
    logic             w_frame_end;
    logic             w_fire;
    logic [15:0]      n_fcs;
    t_eng_in          w_op;
    t_eng_out         w_res;
    t_out_ent         w_ent0;
    t_out_ent         w_ent1;
    logic [1:0]       w_push;
    logic [QUEUE_AW:0] w_q_count;
    logic             w_q_valid;
    t_out_ent         w_q_ent;

    // open a frame on the first real item after a close
    assign w_start   = !r_in_frame;
    assign w_eff_scr = w_start ? r_cfg_scr : r_lat_scr;
    assign w_eff_inv = w_start ? r_cfg_inv : r_lat_inv;
    assign w_eff_fcs = w_start ? FCS_INIT  : r_fcs;
    assign w_fcs_tx  = ~w_eff_fcs;

    always_comb begin
        w_op          = '0;
        w_op.scramble = w_eff_scr;
        w_op.invert   = w_eff_inv;
        w_op.hist     = w_start ? r_cfg_seed : r_hist;
        w_op.ones     = w_start ? 3'd0 : r_ones;
        w_op.pbyte    = w_start ? 8'd0 : r_pbyte;
        w_op.pcnt     = w_start ? 3'd0 : r_pcnt;
        w_active      = 1'b1;
        w_final       = 1'b1;
        w_frame_end   = 1'b0;
        n_fcs         = w_eff_fcs;
        case (r_func)
            FUNC_FLAG: begin
                w_op.data = HDLC_FLAG;
            end
            FUNC_BODY: begin
                w_op.data    = r_data;
                w_op.stuffed = 1'b1;
                n_fcs        = crc_byte(w_eff_fcs, r_data);
            end
            FUNC_END: begin
                case (r_step)
                    STEP_FCS_LO: begin
                        w_op.data    = w_fcs_tx[7:0];
                        w_op.stuffed = 1'b1;
                        w_final      = 1'b0;
                    end
                    STEP_FCS_HI: begin
                        w_op.data    = w_fcs_tx[15:8];
                        w_op.stuffed = 1'b1;
                        w_final      = 1'b0;
                    end
                    STEP_FLAG_A: begin
                        w_op.data  = HDLC_FLAG;
                        w_op.close = w_eff_scr;
                        w_final    = w_eff_scr;
                    end
                    default: begin
                        w_op.data = HDLC_FLAG;
                    end
                endcase
                w_frame_end = w_final;
                if (w_final) begin
                    n_fcs = FCS_INIT;
                end
            end
            default: begin
                // unused kind: drop the item, touch nothing
                w_active = 1'b0;
            end
        endcase
    end

    hsfe_bit_engine u_engine (
        .i_op  (w_op),
        .o_res (w_res)
    );

    assign w_fire        = r_in_valid && (w_q_count <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign s_axis_tready = !r_in_valid || (w_fire && w_final);
    assign w_push        = (w_fire && w_active) ? w_res.nbytes : 2'd0;

    always_comb begin
        w_ent0.data       = w_res.byte0;
        w_ent0.item_last  = w_final && (w_res.nbytes == 2'd1);
        w_ent0.frame_last = w_frame_end && (w_res.nbytes == 2'd1);
        w_ent1.data       = w_res.byte1;
        w_ent1.item_last  = w_final && (w_res.nbytes == 2'd2);
        w_ent1.frame_last = w_frame_end && (w_res.nbytes == 2'd2);
    end

    hsfe_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push),
        .i_ent0     (w_ent0),
        .i_ent1     (w_ent1),
        .i_pop      (m_axis_tready),
        .o_count    (w_q_count),
        .o_valid    (w_q_valid),
        .o_ent      (w_q_ent)
    );

    assign m_axis_tvalid   = w_q_valid;
    assign m_axis_tdata    = w_q_ent.data;
    assign m_axis_tuser[0] = w_q_ent.item_last;
    assign m_axis_tlast    = w_q_ent.frame_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_scr  <= 1'b0;
            r_cfg_seed <= '0;
            r_cfg_inv  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCR_EN: r_cfg_scr  <= i_cfg_data[0];
                CFG_SEED:   r_cfg_seed <= i_cfg_data;
                CFG_INV:    r_cfg_inv  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func <= s_axis_tuser;
            r_data <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_step     <= STEP_FCS_LO;
            r_hist     <= '0;
            r_fcs      <= FCS_INIT;
            r_ones     <= 3'd0;
            r_pbyte    <= 8'd0;
            r_pcnt     <= 3'd0;
            r_in_frame <= 1'b0;
            r_lat_scr  <= 1'b0;
            r_lat_inv  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire && w_final) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_step <= w_final ? STEP_FCS_LO : r_step + 2'd1;
            end
            // the engine clears the partial state itself when a frame closes
            if (w_fire && w_active) begin
                r_hist     <= w_res.hist;
                r_ones     <= w_res.ones;
                r_pbyte    <= w_res.pbyte;
                r_pcnt     <= w_res.pcnt;
                r_fcs      <= n_fcs;
                r_lat_scr  <= w_eff_scr;
                r_lat_inv  <= w_eff_inv;
                r_in_frame <= !w_frame_end;
            end
        end
    end

endmodule

// ===== design/hsfe_bit_engine.sv =====
// Bit engine: stuffs, scrambles, inverts and packs one byte operation.
// Pure combinational; state comes in and goes out through hsfe_pkg structs.
module hsfe_bit_engine
    import hsfe_pkg::*;
(
    input  t_eng_in  i_op,
    output t_eng_out o_res
);

    always_comb begin
        logic [SCR_W-1:0] h;
        logic [2:0]       ones;
        logic [23:0]      buff;
        logic [4:0]       pos;
        logic             sbit;
        logic [1:0]       nfull;
        logic             pad;

        h     = i_op.hist;
        ones  = i_op.ones;
        buff  = {i_op.pbyte, 16'd0};
        pos   = {2'b00, i_op.pcnt};
        sbit  = 1'b0;
        nfull = 2'd0;
        pad   = 1'b0;
        o_res = '0;

        if (i_op.scramble) begin
            // LSB first, stuff a zero after five data ones
            for (int k = 0; k < 8; k++) begin
                sbit = i_op.data[k] ^ h[16] ^ h[11];
                h = {h[SCR_W-2:0], sbit};
                buff[5'd23 - pos] = sbit ^ i_op.invert;
                pos = pos + 5'd1;
                if (i_op.stuffed) begin
                    if (i_op.data[k]) begin
                        if (ones == 3'd4) begin
                            sbit = h[16] ^ h[11];
                            h = {h[SCR_W-2:0], sbit};
                            buff[5'd23 - pos] = sbit ^ i_op.invert;
                            pos = pos + 5'd1;
                            ones = 3'd0;
                        end else begin
                            ones = ones + 3'd1;
                        end
                    end else begin
                        ones = 3'd0;
                    end
                end
            end
            nfull = pos[4:3];
            pad   = i_op.close && (pos[2:0] != 3'd0);
            o_res.hist   = h;
            o_res.ones   = ones;
            o_res.nbytes = nfull + {1'b0, pad};
            o_res.byte0  = buff[23:16];
            o_res.byte1  = buff[15:8];
            o_res.pcnt   = pos[2:0];
            case (nfull)
                2'd0:    o_res.pbyte = buff[23:16];
                2'd1:    o_res.pbyte = buff[15:8];
                default: o_res.pbyte = buff[7:0];
            endcase
            if (i_op.close) begin
                // frame closes: padded tail already emitted, drop partial state
                o_res.pbyte = 8'd0;
                o_res.pcnt  = 3'd0;
                o_res.ones  = 3'd0;
            end
        end else begin
            o_res.hist   = i_op.hist;
            o_res.ones   = i_op.ones;
            o_res.pbyte  = i_op.pbyte;
            o_res.pcnt   = i_op.pcnt;
            o_res.nbytes = 2'd1;
            o_res.byte0  = i_op.data ^ {8{i_op.invert}};
            o_res.byte1  = 8'd0;
        end
    end

endmodule

// ===== design/hsfe_out_queue.sv =====
// Output byte queue: takes up to two items per cycle, hands out one per cycle while i_pop is high.
// Depends on hsfe_pkg for the entry type and depth.
module hsfe_out_queue
    import hsfe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  t_out_ent          i_ent0,
    input  t_out_ent          i_ent1,
    input  logic              i_pop,
    output logic [QUEUE_AW:0] o_count,
    output logic              o_valid,
    output t_out_ent          o_ent
);

    t_out_ent            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW-1:0] n_wp;
    logic [QUEUE_AW-1:0] n_rp;
    logic [QUEUE_AW:0]   n_count;
    logic                w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign n_wp    = r_wp + QUEUE_AW'(i_push_cnt);
    assign n_rp    = r_rp + QUEUE_AW'(w_pop);
    assign n_count = r_count + (QUEUE_AW+1)'(i_push_cnt) - (QUEUE_AW+1)'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_ent0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wp + QUEUE_AW'(1)] <= i_ent1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_valid = (r_count != '0);
    assign o_ent   = r_mem[r_rp];

endmodule
